[design/svgs_pkg.sv]
package svgs_pkg;

  localparam int unsigned LimitWidth = 16;

  localparam logic [LimitWidth-1:0] ScanLimitReset = 16'd1024;
  localparam logic [LimitWidth-1:0] PosMax         = {LimitWidth{1'b1}};

  localparam logic [7:0] BomByte0 = 8'hEF;
  localparam logic [7:0] BomByte1 = 8'hBB;
  localparam logic [7:0] BomByte2 = 8'hBF;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChL     = 8'h6C;

  // Register indexes on the configuration port (word address).
  localparam logic RegScanLimit = 1'b0;

  typedef enum logic [2:0] {
    PH_BOM,
    PH_WS,
    PH_PREFIX,
    PH_SCAN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SVG,
    KIND_XML
  } kind_t;

  typedef enum logic [2:0] {
    VD_EMPTY      = 3'd0,
    VD_NOT_LT     = 3'd1,
    VD_SVG_ROOT   = 3'd2,
    VD_XML_SVG    = 3'd3,
    VD_XML_NO_SVG = 3'd4,
    VD_OTHER_TAG  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic     is_svg;
    verdict_t verdict;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = BomByte0;
      2'd1:    r = BomByte1;
      default: r = BomByte2;
    endcase
    return r;
  endfunction

endpackage

[design/svg_content_sniffer.sv]
// SVG content sniffer.
// Bytes of a file arrive on the s_ stream, one per transfer, with s_tlast on
// the final byte. A leading UTF-8 byte order mark and leading whitespace are
// skipped, and the root is classified. At most one verdict per file leaves on
// the m_ stream: as soon as it is decided, or on the file's last byte; later
// bytes of the same file produce nothing and the sniffer re-arms after tlast.
// scan_limit (APB address 0, reset 1024) bounds the search for an svg tag in
// an xml file.
// Throughput is one byte per cycle while no verdict waits on a stalled
// receiver: each byte passes through an input register, one pass of
// comparison logic and the result register, and a verdict is registered
// and leaves from the result register on m_tvalid.
// When the receiver stalls with a verdict waiting, the classifier holds its
// byte; one more byte can enter the input register, and then s_tready stays
// low until the verdict transfers.
// Synchronous reset clears the stream state and sets scan_limit to 1024.
// The user must write configuration only while no file is in progress; the block itself does not enforce it.
module svg_content_sniffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] is_svg, [3:1] verdict, [7:4] zero
);
  import svgs_pkg::*;

  logic [LimitWidth-1:0] scan_limit;
  item_t                 s_item;
  item_t                 item;
  logic                  item_valid;
  logic                  advance;
  result_t               result;

  assign s_item.data_byte = s_tdata;
  assign s_item.last_byte = s_tlast;

  svgs_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .scan_limit (scan_limit)
  );

  svgs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  svgs_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .scan_limit (scan_limit),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tdata = {4'b0000, result.verdict, result.is_svg};

endmodule

[design/svgs_regs.sv]
module svgs_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [svgs_pkg::LimitWidth-1:0]  scan_limit
);
  import svgs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= ScanLimitReset;
    end else if (wr_en && paddr[2] == RegScanLimit) begin
      scan_limit <= pwdata[LimitWidth-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegScanLimit) begin
      prdata = {{(32-LimitWidth){1'b0}}, scan_limit};
    end
  end

endmodule

[design/svgs_in_reg.sv]
module svgs_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  svgs_pkg::item_t s_item,
  input  logic            advance,
  output logic            item_valid,
  output svgs_pkg::item_t item
);
  import svgs_pkg::*;

  // The held byte moves on whenever the classifier can take it, so a new
  // byte may enter in the same cycle.
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_item;
    end
  end

endmodule

[design/svgs_classify.sv]
module svgs_classify (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [svgs_pkg::LimitWidth-1:0] scan_limit,
  input  logic                            item_valid,
  input  svgs_pkg::item_t                 item,
  output logic                            advance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output svgs_pkg::result_t               result
);
  import svgs_pkg::*;

  phase_t                phase, phase_next;
  kind_t                 kind, kind_next;
  logic [1:0]            bom_index, bom_index_next;
  logic [2:0]            prefix_index, prefix_index_next;
  logic [23:0]           recent_bytes, recent_bytes_next;
  logic [LimitWidth-1:0] scan_position, scan_position_next;

  logic       step;
  logic       v_valid;
  verdict_t   v;
  logic       consumed;
  logic       take;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] want;
  logic       at_limit;
  logic       tag_hit;
  phase_t     eff_phase;

  assign advance = !out_valid || out_ready;
  assign step    = item_valid && advance;
  assign b       = item.data_byte;
  assign c       = to_lower(b);

  // The current trimmed byte is the last one the search may look at.
  assign at_limit = ({1'b0, scan_position} + {{LimitWidth{1'b0}}, 1'b1})
                    >= {1'b0, scan_limit};
  assign tag_hit  = (recent_bytes[23:16] == ChLt) &&
                    (to_lower(recent_bytes[15:8]) == ChS) &&
                    (to_lower(recent_bytes[7:0]) == ChV) &&
                    (c == ChG) && (scan_position < scan_limit);

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    bom_index_next     = bom_index;
    prefix_index_next  = prefix_index;
    recent_bytes_next  = recent_bytes;
    scan_position_next = scan_position;
    v_valid            = 1'b0;
    v                  = VD_EMPTY;
    consumed           = 1'b0;
    take               = 1'b0;
    want               = ChV;

    if (phase == PH_BOM) begin
      if (bom_index != 2'd3 && b == bom_byte(bom_index)) begin
        consumed       = 1'b1;
        bom_index_next = bom_index + 2'd1;
        if (bom_index == 2'd2) begin
          phase_next = PH_WS;
        end
        if (item.last_byte) begin
          v_valid = 1'b1;
          v       = (bom_index == 2'd2) ? VD_EMPTY : VD_NOT_LT;
        end
      end else if (bom_index != 2'd0) begin
        // A broken mark: its first byte counts as the first character.
        consumed = 1'b1;
        v_valid  = 1'b1;
        v        = VD_NOT_LT;
      end else begin
        phase_next = PH_WS;
      end
    end

    eff_phase = (phase == PH_BOM) ? PH_WS : phase;

    if (!consumed) begin
      case (eff_phase)
        PH_WS: begin
          if (is_space(b)) begin
            if (item.last_byte) begin
              v_valid = 1'b1;
              v       = VD_EMPTY;
            end
          end else if (b != ChLt) begin
            v_valid = 1'b1;
            v       = VD_NOT_LT;
          end else begin
            take              = 1'b1;
            phase_next        = PH_PREFIX;
            prefix_index_next = 3'd1;
            if (item.last_byte) begin
              v_valid = 1'b1;
              v       = VD_OTHER_TAG;
            end
          end
        end
        PH_PREFIX: begin
          take = 1'b1;
          if (prefix_index == 3'd1) begin
            if (c == ChS) begin
              kind_next = KIND_SVG;
            end else if (c == ChQuery) begin
              kind_next = KIND_XML;
            end else begin
              v_valid = 1'b1;
              v       = VD_OTHER_TAG;
            end
            prefix_index_next = 3'd2;
          end else if (kind == KIND_SVG) begin
            want = (prefix_index == 3'd2) ? ChV : ChG;
            if (c != want) begin
              v_valid = 1'b1;
              v       = VD_OTHER_TAG;
            end else if (prefix_index == 3'd3) begin
              v_valid = 1'b1;
              v       = VD_SVG_ROOT;
            end
            prefix_index_next = prefix_index + 3'd1;
          end else begin
            want = (prefix_index == 3'd2) ? ChX : (prefix_index == 3'd3) ? ChM : ChL;
            if (c != want) begin
              v_valid = 1'b1;
              v       = VD_OTHER_TAG;
            end else if (prefix_index >= 3'd4) begin
              phase_next = PH_SCAN;
              if (at_limit) begin
                v_valid = 1'b1;
                v       = VD_XML_NO_SVG;
              end
            end
            prefix_index_next = prefix_index + 3'd1;
          end
          if (!v_valid && item.last_byte) begin
            v_valid = 1'b1;
            v       = (phase_next == PH_SCAN) ? VD_XML_NO_SVG : VD_OTHER_TAG;
          end
        end
        PH_SCAN: begin
          take = 1'b1;
          if (tag_hit) begin
            v_valid = 1'b1;
            v       = VD_XML_SVG;
          end else if (at_limit || item.last_byte) begin
            v_valid = 1'b1;
            v       = VD_XML_NO_SVG;
          end
        end
        default: begin
        end
      endcase
    end

    if (take) begin
      recent_bytes_next = {recent_bytes[15:0], b};
      if (scan_position != PosMax) begin
        scan_position_next = scan_position + {{(LimitWidth-1){1'b0}}, 1'b1};
      end
    end

    if (v_valid) begin
      phase_next = PH_DONE;
    end

    // The last byte of a stream re-arms the sniffer for the next one.
    if (item.last_byte) begin
      phase_next         = PH_BOM;
      kind_next          = KIND_NONE;
      bom_index_next     = 2'd0;
      prefix_index_next  = 3'd0;
      recent_bytes_next  = 24'd0;
      scan_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BOM;
      kind          <= KIND_NONE;
      bom_index     <= 2'd0;
      prefix_index  <= 3'd0;
      recent_bytes  <= 24'd0;
      scan_position <= '0;
    end else if (step) begin
      phase         <= phase_next;
      kind          <= kind_next;
      bom_index     <= bom_index_next;
      prefix_index  <= prefix_index_next;
      recent_bytes  <= recent_bytes_next;
      scan_position <= scan_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && v_valid) begin
      result.is_svg  <= (v == VD_SVG_ROOT) || (v == VD_XML_SVG);
      result.verdict <= v;
    end
  end

`ifndef SYNTHESIS
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> phase == PH_BOM && bom_index == 2'd0 &&
      scan_position == '0)
    else $error("sniffer did not re-arm after the last byte");

  a_scan_ctx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SCAN |-> kind == KIND_XML && prefix_index == 3'd5)
    else $error("scan phase entered without a complete xml prefix");

  a_prefix_idx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PREFIX |-> prefix_index >= 3'd1 && prefix_index <= 3'd4)
    else $error("prefix index out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    step && v_valid |=> out_valid)
    else $error("decided verdict was not presented");
`endif

endmodule

[tb/svg_content_sniffer_tb.sv]
module svg_content_sniffer_tb;
  import svgs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] is_svg, [3:1] verdict, [7:4] zero

  svg_content_sniffer u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("FAIL");
    $finish;
  end

  // Stream queues and run statistics.
  item_t       byte_feed[$];
  result_t     pending_verdicts[$];
  logic [7:0]  file_buf[$];
  int          errors = 0;
  int          bytes_queued = 0;
  int          files_queued = 0;
  int          verdicts_checked = 0;
  int          settings_used = 0;
  int          verdict_seen[6];

  // Idling controls; the stimulus process alone writes the percentages and hold requests.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          rx_hold_left = 0;
  bit          in_took = 1'b0;

  // Shadow of the sniffer: configuration and per-file state.
  logic [LimitWidth-1:0] cfg_limit = ScanLimitReset;
  phase_t                sn_phase = PH_BOM;
  logic [1:0]            sn_mark_idx = '0;
  logic [2:0]            sn_prefix_idx = '0;
  kind_t                 sn_kind = KIND_NONE;
  logic [23:0]           sn_recent = '0;
  logic [LimitWidth-1:0] sn_pos = '0;

  item_t   next_item;
  result_t predicted;
  bit      produced;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("MISMATCH (verdict %0d): %s", verdicts_checked, msg);
    end
  endtask

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void rearm_sniffer();
    sn_phase      = PH_BOM;
    sn_mark_idx   = '0;
    sn_prefix_idx = '0;
    sn_kind       = KIND_NONE;
    sn_recent     = '0;
    sn_pos        = '0;
  endfunction

  function automatic void keep_trimmed(input logic [7:0] c);
    sn_recent = {sn_recent[15:0], c};
    if (sn_pos != PosMax) begin
      sn_pos = sn_pos + {{(LimitWidth-1){1'b0}}, 1'b1};
    end
  endfunction

  // Advances the shadow by one byte and says whether a verdict falls due.
  function automatic void sniff_byte(input logic [7:0] b, input logic is_last,
                                     output bit got, output result_t res);
    bit          used;
    logic [7:0]  c;
    logic [7:0]  want;
    int unsigned p;
    verdict_t    v;
    got  = 1'b0;
    used = 1'b0;
    res  = '0;
    v    = VD_EMPTY;
    if (sn_phase == PH_BOM) begin
      want = (sn_mark_idx == 2'd0) ? BomByte0 : (sn_mark_idx == 2'd1) ? BomByte1 : BomByte2;
      if (sn_mark_idx < 2'd3 && b == want) begin
        sn_mark_idx = sn_mark_idx + 2'd1;
        if (sn_mark_idx == 2'd3) begin
          sn_phase = PH_WS;
        end
        if (is_last) begin
          got = 1'b1;
          v   = (sn_mark_idx == 2'd3) ? VD_EMPTY : VD_NOT_LT;
        end
        used = 1'b1;
      end else if (sn_mark_idx != 2'd0) begin
        // A broken mark: its first byte stands as the first byte of the file.
        got  = 1'b1;
        v    = VD_NOT_LT;
        used = 1'b1;
      end else begin
        sn_phase = PH_WS;
      end
    end

    if (!used && sn_phase == PH_WS) begin
      if (is_blank(b)) begin
        if (is_last) begin
          got = 1'b1;
          v   = VD_EMPTY;
        end
      end else if (b != ChLt) begin
        got = 1'b1;
        v   = VD_NOT_LT;
      end else begin
        keep_trimmed(b);
        sn_phase      = PH_PREFIX;
        sn_prefix_idx = 3'd1;
        if (is_last) begin
          got = 1'b1;
          v   = VD_OTHER_TAG;
        end
      end
    end else if (!used && sn_phase == PH_PREFIX) begin
      c = fold_case(b);
      p = 32'(sn_pos);
      keep_trimmed(b);
      if (sn_prefix_idx == 3'd1) begin
        if (c == ChS) begin
          sn_kind = KIND_SVG;
        end else if (c == ChQuery) begin
          sn_kind = KIND_XML;
        end else begin
          got = 1'b1;
          v   = VD_OTHER_TAG;
        end
        sn_prefix_idx = 3'd2;
      end else if (sn_kind == KIND_SVG) begin
        want = (sn_prefix_idx == 3'd2) ? ChV : ChG;
        if (c != want) begin
          got = 1'b1;
          v   = VD_OTHER_TAG;
        end else if (sn_prefix_idx == 3'd3) begin
          got = 1'b1;
          v   = VD_SVG_ROOT;
        end
        sn_prefix_idx = sn_prefix_idx + 3'd1;
      end else begin
        want = (sn_prefix_idx == 3'd2) ? ChX : (sn_prefix_idx == 3'd3) ? ChM : ChL;
        if (c != want) begin
          got = 1'b1;
          v   = VD_OTHER_TAG;
        end else if (sn_prefix_idx >= 3'd4) begin
          sn_phase = PH_SCAN;
          // With a tiny limit the scan window is already used up by the prefix.
          if (p + 1 >= cfg_limit) begin
            got = 1'b1;
            v   = VD_XML_NO_SVG;
          end
        end
        sn_prefix_idx = sn_prefix_idx + 3'd1;
      end
      if (!got && is_last) begin
        got = 1'b1;
        v   = (sn_phase == PH_SCAN) ? VD_XML_NO_SVG : VD_OTHER_TAG;
      end
    end else if (!used && sn_phase == PH_SCAN) begin
      p = 32'(sn_pos);
      if (sn_recent[23:16] == ChLt && fold_case(sn_recent[15:8]) == ChS &&
          fold_case(sn_recent[7:0]) == ChV && fold_case(b) == ChG && p < cfg_limit) begin
        got = 1'b1;
        v   = VD_XML_SVG;
      end else if (p + 1 >= cfg_limit || is_last) begin
        got = 1'b1;
        v   = VD_XML_NO_SVG;
      end
      keep_trimmed(b);
    end

    if (got) begin
      res.is_svg  = (v == VD_SVG_ROOT || v == VD_XML_SVG);
      res.verdict = v;
      sn_phase    = PH_DONE;
    end
    if (is_last) begin
      rearm_sniffer();
    end
  endfunction

  // Byte driver: a new byte is offered only once the previous one has transferred.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = byte_feed.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_item.data_byte;
        s_tlast  <= next_item.last_byte;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Verdict receiver, with a long hold-off whenever the stimulus requests one.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      rx_hold_left = 400;
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on every byte transfer, check on every verdict transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = s_tvalid && s_tready;
      if (in_took) begin
        sniff_byte(s_tdata, s_tlast, produced, predicted);
        if (produced) begin
          pending_verdicts.push_back(predicted);
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none expected", m_tdata[3:1]));
        end else begin
          predicted = pending_verdicts.pop_front();
          if (m_tdata[0] !== predicted.is_svg) begin
            report_mismatch($sformatf("is_svg %b, expected %b", m_tdata[0], predicted.is_svg));
          end
          if (m_tdata[3:1] !== predicted.verdict) begin
            report_mismatch($sformatf("verdict %0d, expected %0d",
                                      m_tdata[3:1], predicted.verdict));
          end
          verdict_seen[predicted.verdict]++;
        end
        verdicts_checked++;
      end
    end
  end

  task automatic apb_cycle(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_scan_limit(input logic [LimitWidth-1:0] lim);
    logic [31:0] rd;
    apb_cycle(1'b1, {RegScanLimit, 2'b00}, {16'd0, lim}, rd);
    cfg_limit = lim;
    apb_cycle(1'b0, {RegScanLimit, 2'b00}, 32'd0, rd);
    if (rd[LimitWidth-1:0] !== lim) begin
      report_mismatch($sformatf("scan_limit reads %0d, written %0d", rd[15:0], lim));
    end
    settings_used++;
  endtask

  // Waits for every byte to transfer and every verdict to arrive, then lets
  // the pipeline settle, since the trailing bytes of a file give no verdict.
  task automatic drain();
    while (byte_feed.size() != 0 || s_tvalid || pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_file();
    item_t it;
    foreach (file_buf[i]) begin
      it.data_byte = file_buf[i];
      it.last_byte = (i == file_buf.size() - 1);
      byte_feed.push_back(it);
    end
    bytes_queued += file_buf.size();
    files_queued++;
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) != 0) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(5) == 0) begin
      return 8'h20;
    end
    return 8'h09 + 8'($urandom_range(4));
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(9))
      0, 1:    return ChLt;
      2:       return any_case(ChS);
      3:       return any_case(ChV);
      4:       return any_case(ChG);
      5:       return 8'h20;
      6:       return 8'h3E;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_random_file();
    int         pick;
    int         n;
    int         body;
    int         at;
    int         window;
    bit         stretch;
    logic [7:0] hdr[5];
    file_buf.delete();
    pick = $urandom_range(99);
    if (pick < 80 || (pick >= 88 && pick < 92)) begin
      if ($urandom_range(2) == 0) begin
        file_buf.push_back(BomByte0);
        file_buf.push_back(BomByte1);
        file_buf.push_back(BomByte2);
      end
      n = ($urandom_range(2) == 0) ? $urandom_range(4) : 0;
      repeat (n) file_buf.push_back(blank_char());
    end
    if (pick < 25) begin
      file_buf.push_back(ChLt);
      file_buf.push_back(any_case(ChS));
      file_buf.push_back(any_case(ChV));
      file_buf.push_back(any_case(ChG));
      repeat ($urandom_range(3)) file_buf.push_back(body_char());
    end else if (pick < 68) begin
      file_buf.push_back(ChLt);
      file_buf.push_back(ChQuery);
      file_buf.push_back(any_case(ChX));
      file_buf.push_back(any_case(ChM));
      file_buf.push_back(any_case(ChL));
      stretch = cfg_limit >= 9 &&
                ((cfg_limit <= 64 && $urandom_range(5) == 0) ||
                 (cfg_limit <= 1100 && $urandom_range(39) == 0));
      if (stretch) begin
        // Tag placed so that its last letter sits just inside or just past the window.
        body = cfg_limit - 3;
        at   = cfg_limit - 9 + $urandom_range(1);
      end else begin
        window = (cfg_limit > 48) ? 48 : cfg_limit;
        body   = $urandom_range(window + 4);
        at     = $urandom_range(body);
      end
      for (int i = 0; i <= body; i++) begin
        if (i == at && (stretch || $urandom_range(3) != 0)) begin
          file_buf.push_back(ChLt);
          file_buf.push_back(any_case(ChS));
          file_buf.push_back(any_case(ChV));
          file_buf.push_back(any_case(ChG));
        end
        if (i < body) begin
          file_buf.push_back(body_char());
        end
      end
    end else if (pick < 80) begin
      // A root cut short, sometimes followed by one stray byte.
      if ($urandom_range(1) != 0) begin
        hdr = '{ChLt, ChS, ChV, ChG, 8'h00};
        n   = 4;
      end else begin
        hdr = '{ChLt, ChQuery, ChX, ChM, ChL};
        n   = 5;
      end
      at = $urandom_range(n - 1, 1);
      for (int i = 0; i < at; i++) begin
        file_buf.push_back(any_case(hdr[i]));
      end
      if ($urandom_range(1) != 0) begin
        file_buf.push_back(body_char());
      end
    end else if (pick < 88) begin
      file_buf.push_back(BomByte0);
      if ($urandom_range(1) != 0) begin
        file_buf.push_back(BomByte1);
      end
      if ($urandom_range(1) != 0) begin
        file_buf.push_back(8'($urandom_range(255)));
      end
    end else if (pick >= 92) begin
      repeat ($urandom_range(6, 1)) file_buf.push_back(8'($urandom_range(255)));
    end
    if (file_buf.size() == 0) begin
      file_buf.push_back(blank_char());
    end
    queue_file();
  endtask

  initial begin
    int unsigned limit_plan[10];
    int          target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files at the reset limit.
    file_buf = '{ChLt, ChS, ChV, ChG, 8'h41};
    queue_file();
    file_buf = '{BomByte0, BomByte1, BomByte2, 8'h0D, ChLt, 8'h53, 8'h56, 8'h47};
    queue_file();
    file_buf = '{BomByte0, 8'h00};
    queue_file();
    file_buf = '{BomByte0, BomByte1};
    queue_file();
    file_buf = '{BomByte0, BomByte1, BomByte2};
    queue_file();
    file_buf = '{8'h09, 8'h0D, 8'h20};
    queue_file();
    file_buf = '{8'hFF};
    queue_file();
    file_buf = '{ChLt, ChQuery};
    queue_file();
    file_buf = '{ChLt, 8'h61};
    queue_file();
    file_buf = '{ChLt};
    queue_file();
    file_buf = '{ChLt, ChQuery, 8'h58, ChM, 8'h4C, ChLt, ChS, 8'h56, ChG};
    queue_file();
    drain();

    limit_plan = '{4, 65535, 9, 8, 1024, 10, 5, 12,
                   $urandom_range(64, 13), $urandom_range(2000, 4)};
    for (int ph = 0; ph < 10; ph++) begin
      set_scan_limit(limit_plan[ph][15:0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 0) begin
        // Long receiver hold-off with the sender running flat out, then a
        // pause until every verdict is in, then the rest of the phase.
        hold_requests++;
        target = bytes_queued + 100;
        while (bytes_queued < target) add_random_file();
        drain();
      end
      target = bytes_queued + 200;
      while (bytes_queued < target) add_random_file();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d verdicts from %0d files (%0d bytes) under %0d scan_limit settings.",
             verdicts_checked, files_queued, bytes_queued, settings_used);
    $display("Verdicts seen: empty %0d, not a tag %0d, svg root %0d, %s %0d, %s %0d, %s %0d.",
             verdict_seen[0], verdict_seen[1], verdict_seen[2],
             "xml with svg", verdict_seen[3],
             "xml without svg", verdict_seen[4], "other tag", verdict_seen[5]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
